@@ design/bounded_deque_with_search_defines.svh @@
// Assertion macros used by the bounded deque top level.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH
`define BOUNDED_DEQUE_WITH_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BDS_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BDS_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/bds_pkg.sv @@
// Package for the bounded deque with search: field widths, codes and the
// command and status structs between controller and datapath. No dependencies.
package bds_pkg;

    localparam int DEPTH_DEF     = 16;
    localparam int WORD_BITS_DEF = 32;

    localparam int FUNC_W    = 3;
    localparam int VALUE_W   = 32;
    localparam int STATUS_W  = 2;
    localparam int POS_W     = 4;
    localparam int CNT_OUT_W = 5;
    localparam int CAP_W     = 5;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_BACK  = 3'd0,
        FN_PUSH_FRONT = 3'd1,
        FN_POP_FRONT  = 3'd2,
        FN_POP_BACK   = 3'd3,
        FN_SEARCH     = 3'd4
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP_FIN,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_EMIT
    } bds_state_t;

    typedef struct packed {
        logic take;
        logic at_front;
        logic push_exec;
        logic set_full;
        logic set_empty;
        logic pop_read;
        logic pop_finish;
        logic srch_hit;
        logic srch_next;
        logic emit;
    } bds_cmd_t;

    typedef struct packed {
        func_t in_func;
        func_t cur_func;
        logic  full;
        logic  empty;
        logic  k_end;
        logic  match;
        logic  out_free;
    } bds_stat_t;

endpackage

@@ design/bds_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module bds_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bds_ctrl.sv @@
// Controller state machine of the bounded deque: sequences pushes, pops,
// searches and result hand-off. Depends on bds_pkg.
module bds_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  bds_pkg::bds_stat_t  stat,
    output bds_pkg::bds_cmd_t   cmd
);
    import bds_pkg::*;

    bds_state_t state_reg;
    bds_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (stat.in_func)
                        FN_POP_FRONT, FN_POP_BACK:
                        begin
                            state_next = stat.empty ? S_EMIT : S_POP_FIN;
                        end
                        FN_SEARCH:
                        begin
                            state_next = S_SRCH_RD;
                        end
                        default:
                        begin
                            state_next = S_EMIT;
                        end
                    endcase
                end
            end
            S_POP_FIN:
            begin
                state_next = S_EMIT;
            end
            S_SRCH_RD:
            begin
                state_next = stat.k_end ? S_EMIT : S_SRCH_CMP;
            end
            S_SRCH_CMP:
            begin
                state_next = stat.match ? S_EMIT : S_SRCH_RD;
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.take = 1'b1;
                    case (stat.in_func)
                        FN_PUSH_BACK, FN_PUSH_FRONT:
                        begin
                            cmd.at_front  = (stat.in_func == FN_PUSH_FRONT);
                            cmd.set_full  = stat.full;
                            cmd.push_exec = !stat.full;
                        end
                        FN_POP_FRONT, FN_POP_BACK:
                        begin
                            cmd.at_front  = (stat.in_func == FN_POP_FRONT);
                            cmd.set_empty = stat.empty;
                            cmd.pop_read  = !stat.empty;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_FIN:
            begin
                cmd.at_front   = (stat.cur_func == FN_POP_FRONT);
                cmd.pop_finish = 1'b1;
            end
            S_SRCH_CMP:
            begin
                cmd.srch_hit  = stat.match;
                cmd.srch_next = !stat.match;
            end
            S_EMIT:
            begin
                cmd.emit = stat.out_free;
            end
            default:
            begin
            end
        endcase
    end

endmodule

@@ design/bds_dpath.sv @@
// Datapath of the bounded deque: pointers, count, capacity, entry store,
// result and output registers. Depends on bds_pkg and bds_ram.
module bds_dpath #(
    parameter int DEPTH     = bds_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bds_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [bds_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bds_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [bds_pkg::CAP_W-1:0]     cfg_data,
    input  bds_pkg::bds_cmd_t             cmd,
    output bds_pkg::bds_stat_t            stat
);
    import bds_pkg::*;

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int KW    = (WORD_BITS < VALUE_W) ? WORD_BITS : VALUE_W;

    logic [PTR_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CAP_W-1:0]   cap_reg;
    logic [CNT_W-1:0]   k_reg, k_next;
    func_t              func_reg;
    logic [VALUE_W-1:0] val_reg;

    status_t            res_status_reg;
    logic [VALUE_W-1:0] res_oval_reg;
    logic               res_found_reg;
    logic [POS_W-1:0]   res_pos_reg;

    logic               out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic [PTR_W-1:0]     head_inc, head_dec, back_slot, last_slot, srch_slot;
    logic [PTR_W-1:0]     ram_addr;
    logic [WORD_BITS-1:0] ram_rdata;
    logic [WORD_BITS-1:0] in_word;
    logic [WORD_BITS-1:0] key_word;
    logic [CMP_W-1:0]     count_ext, cap_ext, k_ext;
    logic [VALUE_W-1:0]   in_value;
    logic                 out_free;

    function automatic logic [PTR_W-1:0] wrap(input logic [PTR_W:0] s);
        logic [PTR_W:0] r;
        r = (s >= (PTR_W + 1)'(DEPTH)) ? s - (PTR_W + 1)'(DEPTH) : s;
        return r[PTR_W-1:0];
    endfunction

    assign in_value = s_tdata[FUNC_W +: VALUE_W];
    assign in_word  = WORD_BITS'(in_value[KW-1:0]);
    assign key_word = WORD_BITS'(val_reg[KW-1:0]);

    assign head_inc  = (head_reg == PTR_W'(DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign head_dec  = (head_reg == '0) ? PTR_W'(DEPTH - 1) : head_reg - PTR_W'(1);
    assign back_slot = wrap((PTR_W + 1)'(head_reg) + (PTR_W + 1)'(count_reg));
    assign last_slot = wrap((PTR_W + 1)'(head_reg) + (PTR_W + 1)'(count_reg - CNT_W'(1)));
    assign srch_slot = wrap((PTR_W + 1)'(head_reg) + (PTR_W + 1)'(k_reg));

    always_comb
    begin
        if (cmd.push_exec)
        begin
            ram_addr = cmd.at_front ? head_dec : back_slot;
        end
        else if (cmd.pop_read)
        begin
            ram_addr = cmd.at_front ? head_reg : last_slot;
        end
        else
        begin
            ram_addr = srch_slot;
        end
    end

    bds_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.push_exec),
        .waddr (ram_addr),
        .wdata (in_word),
        .raddr (ram_addr),
        .rdata (ram_rdata)
    );

    assign count_ext = CMP_W'(count_reg);
    assign cap_ext   = CMP_W'(cap_reg);
    assign k_ext     = CMP_W'(k_reg);
    assign out_free  = !out_valid_reg || m_tready;

    always_comb
    begin
        stat.in_func  = func_t'(s_tdata[FUNC_W-1:0]);
        stat.cur_func = func_reg;
        stat.full     = (count_reg == CNT_W'(DEPTH))
                        || ((cap_reg != '0) && (count_ext >= cap_ext));
        stat.empty    = (count_reg == '0);
        stat.k_end    = (k_reg == count_reg);
        stat.match    = (ram_rdata == key_word);
        stat.out_free = out_free;
    end

    always_comb
    begin
        head_next  = head_reg;
        count_next = count_reg;
        k_next     = k_reg;
        if (cmd.take)
        begin
            k_next = '0;
        end
        if (cmd.push_exec)
        begin
            count_next = count_reg + CNT_W'(1);
            if (cmd.at_front)
            begin
                head_next = head_dec;
            end
        end
        if (cmd.pop_finish)
        begin
            count_next = count_reg - CNT_W'(1);
            if (cmd.at_front)
            begin
                head_next = head_inc;
            end
        end
        if (cmd.srch_next)
        begin
            k_next = k_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            k_reg     <= k_next;
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            func_reg       <= stat.in_func;
            val_reg        <= in_value;
            res_oval_reg   <= '0;
            res_found_reg  <= 1'b0;
            res_pos_reg    <= '0;
            if (cmd.set_full)
            begin
                res_status_reg <= STAT_FULL;
            end
            else if (cmd.set_empty)
            begin
                res_status_reg <= STAT_EMPTY;
            end
            else
            begin
                res_status_reg <= STAT_DONE;
            end
        end
        if (cmd.pop_finish)
        begin
            res_oval_reg <= VALUE_W'(ram_rdata[KW-1:0]);
        end
        if (cmd.srch_hit)
        begin
            res_found_reg <= 1'b1;
            res_pos_reg   <= k_ext[POS_W-1:0];
            res_oval_reg  <= VALUE_W'(key_word[KW-1:0]);
        end
        if (cmd.emit)
        begin
            out_data_reg <= M_TDATA_W'({count_ext[CNT_OUT_W-1:0], res_pos_reg,
                                        res_found_reg, res_oval_reg, res_status_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

@@ design/bounded_deque_with_search.sv @@
// Top level of the bounded double-ended queue with search by equality.
// Depends on bds_pkg, bds_ctrl, bds_dpath, bds_ram and the defines header.
//
// The block holds up to DEPTH words in a circular store and takes one
// operation per input beat: push back, push front, pop front, pop back or
// search from the front; unused codes return the current count. Each beat
// yields one result beat with status, value, found flag, position and
// count. A pop of a non-empty deque passes through the extra S_POP_FIN
// state because of the registered store read, and a search examines one
// entry at a time through the single store read port, in the states
// S_SRCH_RD and S_SRCH_CMP.
// The next input beat is taken once the result has moved to the output
// register, which holds it while the output side stalls. The capacity
// register may be written at any time the block is idle; zero or a value
// above DEPTH allows the full depth.
`include "bounded_deque_with_search_defines.svh"

module bounded_deque_with_search #(
    parameter int DEPTH     = bds_pkg::DEPTH_DEF,
    parameter int WORD_BITS = bds_pkg::WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // s_tdata: func [2:0], value [34:3], zero fill [39:35]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bds_pkg::S_TDATA_W-1:0] s_tdata,
    // m_tdata: status [1:0], out_value [33:2], found [34], position [38:35],
    // count_after [43:39], zero fill [47:44]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bds_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_we,
    input  logic [bds_pkg::CAP_W-1:0]     cfg_data
);
    import bds_pkg::*;

    localparam int OFS_VALUE = STATUS_W;
    localparam int OFS_FOUND = OFS_VALUE + VALUE_W;
    localparam int OFS_POS   = OFS_FOUND + 1;
    localparam int OFS_CNT   = OFS_POS + POS_W;

    bds_cmd_t  cmd;
    bds_stat_t stat;

    bds_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bds_dpath #(
        .DEPTH     (DEPTH),
        .WORD_BITS (WORD_BITS)
    ) u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat)
    );

    `BDS_ASSERT_SAME(a_emit_free, cmd.emit, !m_tvalid || m_tready, "result overwrote a pending beat")
    `BDS_ASSERT_SAME(a_empty_not_full, stat.empty, !stat.full, "empty queue reported full")
    `BDS_ASSERT_SAME(a_found_pos, m_tvalid && m_tdata[OFS_FOUND],
        (m_tdata[STATUS_W-1:0] == STAT_DONE)
        && (m_tdata[OFS_POS +: POS_W] < m_tdata[OFS_CNT +: CNT_OUT_W]),
        "search hit with bad status or position")
    `BDS_ASSERT_NEXT(a_take_leaves_idle, cmd.take, !s_tready, "accepted beat did not start work")

endmodule

@@ verif/bounded_deque_with_search_tb.sv @@
// Self-checking testbench for bounded_deque_with_search: a stream driver and monitor with an
// inline deque predictor, random burst and stall patterns, and capacity changes between phases.
// Depends on bds_pkg and the bounded_deque_with_search RTL.
module bounded_deque_with_search_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bds_pkg::*;

    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 40;
    localparam int IDLE_LIMIT    = 1000;
    localparam int HOLD_CYCLES   = 120;
    localparam int HOLD_AFTER    = 400;
    localparam int POOL_MAX      = 24;

    localparam logic [FUNC_W-1:0] FN_SPARE_LO  = 3'd5;
    localparam logic [FUNC_W-1:0] FN_SPARE_MID = 3'd6;
    localparam logic [FUNC_W-1:0] FN_SPARE_HI  = 3'd7;

    typedef enum logic [1:0] {
        STEP_BEAT,
        STEP_CFG,
        STEP_SYNC
    } step_kind_t;

    typedef struct {
        step_kind_t          kind;
        logic [FUNC_W-1:0]   func;
        logic [VALUE_W-1:0]  value;
        logic [CAP_W-1:0]    cap;
    } stim_step_t;

    typedef struct {
        status_t               status;
        logic [VALUE_W-1:0]    value;
        logic                  found;
        logic [POS_W-1:0]      position;
        logic [CNT_OUT_W-1:0]  count;
    } deque_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_we = 1'b0;
    logic [CAP_W-1:0]      cfg_data = '0;

    stim_step_t      stim_queue[$];
    deque_result_t   expected_results[$];
    logic [VALUE_W-1:0] pushed_words[$];

    logic [VALUE_W-1:0]   shadow_store[DEPTH_DEF];
    logic [POS_W-1:0]     shadow_head = '0;
    logic [CNT_OUT_W-1:0] shadow_count = '0;
    logic [CAP_W-1:0]     shadow_cap = '0;

    int   error_count = 0;
    int   results_seen = 0;
    int   idle_cycles = 0;
    logic in_took = 1'b0;

    int   burst_left = 1;
    int   gap_left = 0;
    int   settle_cnt = 0;
    stim_step_t           head_step;
    logic                 nv_valid;
    logic [S_TDATA_W-1:0] nv_data;
    logic                 nv_we;
    logic [CAP_W-1:0]     nv_cap;

    int   hold_left = 0;
    logic hold_done = 1'b0;
    int   run_left = 0;
    int   ready_pct = 100;

    deque_result_t got;
    deque_result_t want;

    bounded_deque_with_search u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic deque_result_t deque_apply(logic [FUNC_W-1:0] func,
                                                  logic [VALUE_W-1:0] word);
        deque_result_t r;
        int            lim;
        logic [POS_W-1:0] slot;
        r.status   = STAT_DONE;
        r.value    = '0;
        r.found    = 1'b0;
        r.position = '0;
        lim = (shadow_cap == 0 || shadow_cap > DEPTH_DEF) ? DEPTH_DEF : int'(shadow_cap);
        case (func)
            FN_PUSH_BACK:
            begin
                if (shadow_count >= lim)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    slot = shadow_head + shadow_count[POS_W-1:0];
                    shadow_store[slot] = word;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            FN_PUSH_FRONT:
            begin
                if (shadow_count >= lim)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_store[shadow_head] = word;
                    shadow_count = shadow_count + 1'b1;
                end
            end
            FN_POP_FRONT:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    r.value = shadow_store[shadow_head];
                    shadow_head = shadow_head + 1'b1;
                    shadow_count = shadow_count - 1'b1;
                end
            end
            FN_POP_BACK:
            begin
                if (shadow_count == 0)
                begin
                    r.status = STAT_EMPTY;
                end
                else
                begin
                    slot = shadow_head + shadow_count[POS_W-1:0] - 1'b1;
                    r.value = shadow_store[slot];
                    shadow_count = shadow_count - 1'b1;
                end
            end
            FN_SEARCH:
            begin
                for (int k = 0; k < shadow_count; k++)
                begin
                    slot = shadow_head + k[POS_W-1:0];
                    if (shadow_store[slot] == word)
                    begin
                        r.found    = 1'b1;
                        r.position = k[POS_W-1:0];
                        r.value    = word;
                        break;
                    end
                end
            end
            default:
            begin
            end
        endcase
        r.count = shadow_count;
        return r;
    endfunction

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic add_beat(input logic [FUNC_W-1:0] func, input logic [VALUE_W-1:0] word);
        stim_step_t s;
        s.kind  = STEP_BEAT;
        s.func  = func;
        s.value = word;
        s.cap   = '0;
        stim_queue.push_back(s);
    endtask

    task automatic add_marker(input step_kind_t kind, input logic [CAP_W-1:0] cap);
        stim_step_t s;
        s.kind  = kind;
        s.func  = '0;
        s.value = '0;
        s.cap   = cap;
        stim_queue.push_back(s);
    endtask

    function automatic logic [VALUE_W-1:0] pick_extreme();
        case ($urandom_range(0, 2))
            0:       return '0;
            1:       return '1;
            default: return 32'h7000_0000;
        endcase
    endfunction

    function automatic logic [VALUE_W-1:0] pick_word(input int pool_pct);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return pick_extreme();
        if (r < 10 + pool_pct && pushed_words.size() > 0)
            return pushed_words[$urandom_range(0, pushed_words.size() - 1)];
        return $urandom;
    endfunction

    task automatic build_stimulus();
        logic [CAP_W-1:0]   caps[10];
        int                 bias;
        int                 r;
        int                 push_pct;
        int                 pop_pct;
        logic [FUNC_W-1:0]  func;
        logic [VALUE_W-1:0] word;
        caps = '{5'd0, 5'd16, 5'd1, 5'd2, 5'd7, 5'd31, 5'd4, 5'd0, 5'd12, 5'd16};

        add_beat(FN_POP_FRONT, 32'h5555_5555);
        add_beat(FN_POP_BACK, 32'hAAAA_AAAA);
        add_beat(FN_SEARCH, 32'h0);
        add_beat(FN_PUSH_BACK, 32'h0);
        add_beat(FN_PUSH_BACK, 32'hFFFF_FFFF);
        add_beat(FN_PUSH_FRONT, 32'h7000_0000);
        add_beat(FN_PUSH_FRONT, 32'h1234_5678);
        add_beat(FN_SEARCH, 32'hFFFF_FFFF);
        add_beat(FN_SEARCH, 32'h7000_0000);
        add_beat(FN_SEARCH, 32'hDEAD_BEEF);
        add_beat(FN_SPARE_LO, 32'hFFFF_FFFF);
        add_beat(FN_SPARE_MID, 32'h0);
        add_beat(FN_SPARE_HI, 32'h8000_0001);
        add_beat(FN_POP_BACK, 32'h0);
        add_beat(FN_POP_FRONT, 32'h0);
        // Capacity below the current count: pushes are refused until pops bring the count below it.
        add_marker(STEP_CFG, 5'd1);
        add_beat(FN_PUSH_BACK, 32'h0000_0001);
        add_beat(FN_PUSH_FRONT, 32'h0000_0002);
        add_beat(FN_SEARCH, 32'h0);
        add_beat(FN_POP_BACK, 32'h0);
        add_beat(FN_POP_FRONT, 32'h0);
        add_beat(FN_PUSH_BACK, 32'hCAFE_0001);
        // A capacity above the depth saturates to the full depth.
        add_marker(STEP_CFG, 5'd31);
        add_beat(FN_PUSH_FRONT, 32'h8000_0000);
        add_beat(FN_SEARCH, 32'hCAFE_0001);

        bias = 2;
        foreach (caps[i])
        begin
            add_marker(STEP_CFG, caps[i]);
            for (int n = 0; n < 105; n++)
            begin
                if (n % 15 == 0)
                    bias = $urandom_range(0, 2);
                if (n == 52 && i % 3 == 1)
                    add_marker(STEP_SYNC, '0);
                push_pct = (bias == 0) ? 65 : (bias == 1) ? 20 : 35;
                pop_pct  = (bias == 0) ? 15 : (bias == 1) ? 55 : 35;
                r = $urandom_range(0, 99);
                if (r < 3)
                begin
                    func = FUNC_W'($urandom_range(FN_SPARE_LO, FN_SPARE_HI));
                    word = $urandom;
                end
                else
                begin
                    r = $urandom_range(0, 99);
                    if (r < push_pct)
                    begin
                        func = $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
                        word = pick_word(30);
                        pushed_words.push_back(word);
                        if (pushed_words.size() > POOL_MAX)
                            void'(pushed_words.pop_front());
                    end
                    else if (r < push_pct + pop_pct)
                    begin
                        func = $urandom_range(0, 1) ? FN_POP_BACK : FN_POP_FRONT;
                        word = $urandom;
                    end
                    else
                    begin
                        func = FN_SEARCH;
                        word = pick_word(60);
                    end
                end
                add_beat(func, word);
            end
        end
    endtask

    // Sender: beats in random bursts, capacity writes only once the block has drained.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            nv_valid = s_tvalid;
            nv_data  = s_tdata;
            nv_we    = 1'b0;
            nv_cap   = cfg_data;
            if (!(s_tvalid && !in_took))
            begin
                nv_valid = 1'b0;
                if (gap_left > 0)
                begin
                    gap_left--;
                end
                else if (stim_queue.size() > 0)
                begin
                    head_step = stim_queue[0];
                    if (head_step.kind == STEP_BEAT)
                    begin
                        void'(stim_queue.pop_front());
                        nv_valid = 1'b1;
                        nv_data  = {{(S_TDATA_W-FUNC_W-VALUE_W){1'b0}},
                                    head_step.value, head_step.func};
                        burst_left--;
                        if (burst_left <= 0)
                        begin
                            burst_left = $urandom_range(1,
                                ($urandom_range(0, 3) == 0) ? 60 : 8);
                            gap_left = ($urandom_range(0, 3) == 0) ? 0 :
                                $urandom_range(1, 12);
                        end
                    end
                    else if (!s_tvalid && expected_results.size() == 0)
                    begin
                        if (settle_cnt < SETTLE_CYCLES)
                        begin
                            settle_cnt++;
                        end
                        else
                        begin
                            settle_cnt = 0;
                            void'(stim_queue.pop_front());
                            if (head_step.kind == STEP_CFG)
                            begin
                                nv_we  = 1'b1;
                                nv_cap = head_step.cap;
                            end
                        end
                    end
                    else
                    begin
                        settle_cnt = 0;
                    end
                end
            end
            s_tvalid <= nv_valid;
            s_tdata  <= nv_data;
            cfg_we   <= nv_we;
            cfg_data <= nv_cap;
        end
    end

    // Receiver: runs of varying readiness, plus one long hold-off that backs the block up.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end
            else
            begin
                if (run_left <= 0)
                begin
                    run_left = $urandom_range(1, 30);
                    case ($urandom_range(0, 3))
                        0:       ready_pct = 100;
                        1:       ready_pct = 25;
                        default: ready_pct = 60;
                    endcase
                end
                run_left--;
                m_tready <= ($urandom_range(0, 99) < ready_pct);
            end
        end
    end

    // Monitor: checks result beats, predicts accepted input beats, and watches for hangs.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                got.status   = status_t'(m_tdata[1:0]);
                got.value    = m_tdata[33:2];
                got.found    = m_tdata[34];
                got.position = m_tdata[38:35];
                got.count    = m_tdata[43:39];
                if (expected_results.size() == 0)
                begin
                    flag_error($sformatf("result beat with none expected: %h", m_tdata));
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                        flag_error($sformatf("status %0d, expected %0d",
                                             got.status, want.status));
                    if (got.value !== want.value)
                        flag_error($sformatf("out_value %h, expected %h",
                                             got.value, want.value));
                    if (got.found !== want.found)
                        flag_error($sformatf("found %b, expected %b",
                                             got.found, want.found));
                    if (got.position !== want.position)
                        flag_error($sformatf("position %0d, expected %0d",
                                             got.position, want.position));
                    if (got.count !== want.count)
                        flag_error($sformatf("count_after %0d, expected %0d",
                                             got.count, want.count));
                end
            end
            if (cfg_we)
                shadow_cap = cfg_data;
            if (s_tvalid && s_tready)
                expected_results.push_back(deque_apply(s_tdata[FUNC_W-1:0],
                                                       s_tdata[FUNC_W+VALUE_W-1:FUNC_W]));
            in_took <= s_tvalid && s_tready;

            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || cfg_we)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("watchdog: no beat for %0d cycles", idle_cycles);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        build_stimulus();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        do
            @(posedge clk);
        while (stim_queue.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
